@@ rtl/core/extent_allocator_fit_policies_top_defines.svh @@
// Assertion macros for the extent allocator.
// Each takes label, clock, reset, the check (or antecedent and consequent), message.
`ifndef EXTENT_ALLOCATOR_FIT_POLICIES_TOP_DEFINES_SVH
`define EXTENT_ALLOCATOR_FIT_POLICIES_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define EFP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define EFP_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define EFP_ASSERT(lbl, clk, rst, prop, msg)
`define EFP_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/core/efp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Extent allocator package
// Field widths, command, status and policy codes, register indexes and the
// controller states of the extent allocator.
// ----------------------------------------------------------------------------
package efp_pkg;

   localparam int FIELD_W   = 16;
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 5;
   localparam int CSR_IDX_W = 2;
   localparam int POLICY_W  = 2;

   localparam logic [FIELD_W-1:0] POOL_RESET = 16'd1000;

   localparam logic [CSR_IDX_W-1:0] CSR_FIT_POLICY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_SIZE  = 2'd1;

   typedef enum logic [CMD_W-1:0] {
      CMD_INIT  = 2'd0,
      CMD_ALLOC = 2'd1,
      CMD_FREE  = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_NOFIT = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [POLICY_W-1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_WORST = 2'd2
   } policy_type;

   typedef enum logic [2:0] {
      S_BOOT,
      S_IDLE,
      S_A_SCAN,
      S_A_MOVE,
      S_F_RUN,
      S_DONE
   } state_type;

endpackage : efp_pkg
`default_nettype wire

@@ rtl/core/efp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Extent allocator channels
// Command, result and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface efp_req_if;
   logic                          valid;
   logic                          ready;
   logic [efp_pkg::CMD_W-1:0]     cmd;
   logic [efp_pkg::FIELD_W-1:0]   block_size;
   logic [efp_pkg::FIELD_W-1:0]   block_start;
   modport source (output valid, cmd, block_size, block_start, input ready);
   modport sink   (input valid, cmd, block_size, block_start, output ready);
endinterface : efp_req_if

interface efp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [efp_pkg::STATUS_W-1:0]  status;
   logic [efp_pkg::FIELD_W-1:0]   alloc_start;
   logic [efp_pkg::COUNT_W-1:0]   free_extent_count;
   modport source (output valid, status, alloc_start, free_extent_count, input ready);
   modport sink   (input valid, status, alloc_start, free_extent_count, output ready);
endinterface : efp_rsp_if

interface efp_csr_if;
   logic                          valid;
   logic                          ready;
   logic [efp_pkg::CSR_IDX_W-1:0] index;
   logic [efp_pkg::FIELD_W-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface : efp_csr_if
`default_nettype wire

@@ rtl/core/extent_allocator_fit_policies_top.sv @@
// Commands are handled one at a time; the extent memory's single read port sets the pace,
// one entry per cycle. An allocate scans the table and, when an extent empties, moves the
// entries above it down; a free streams the table once to count and, if it fits, again
// to rewrite it. Reset (synchronous, active high) clears control state and writes the
// default extent [0, 1000) into entry zero before the first command is taken.
`default_nettype none
// ----------------------------------------------------------------------------
// Extent allocator with first, best and worst fit
// Free extents live in one synchronous memory sorted by base address; a
// sequencer scans, rewrites and compacts the table one entry per cycle.
// ----------------------------------------------------------------------------
`include "extent_allocator_fit_policies_top_defines.svh"

module extent_allocator_fit_policies_top #(
   parameter int MAX_EXTENTS = 16,
   parameter int ADDR_BITS   = 16
) (
   input  wire     clock,
   input  wire     reset,
   efp_req_if.sink   req_chan,
   efp_rsp_if.source rsp_chan,
   efp_csr_if.sink   csr_chan
);
   import efp_pkg::*;

   // Index into the memory, count of held extents, and count during a free
   // (which may briefly reach one past the table size).
   localparam int IW = $clog2(MAX_EXTENTS);
   localparam int CW = $clog2(MAX_EXTENTS + 1);
   localparam int MW = $clog2(MAX_EXTENTS + 2);
   localparam int AW = ADDR_BITS;

   // Each memory word holds one extent: base in the upper half, length in the lower.
   logic [2*AW-1:0] mem [MAX_EXTENTS];
   logic [2*AW-1:0] mem_q;
   logic            mem_we;
   logic [IW-1:0]   mem_wa;
   logic [2*AW-1:0] mem_wd;
   logic [IW-1:0]   rd_addr;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] j_ff, j_in;
   logic [MW-1:0] m_ff, m_in;
   logic [AW-1:0] size_ff, size_in;
   logic [AW-1:0] start_ff, start_in;
   logic [AW-1:0] acc_b_ff, acc_b_in;
   logic [AW-1:0] acc_l_ff, acc_l_in;
   logic [AW-1:0] pick_b_ff, pick_b_in;
   logic [AW-1:0] pick_l_ff, pick_l_in;
   logic [IW-1:0] pick_idx_ff, pick_idx_in;
   logic          found_ff, found_in;
   logic          ins_ff, ins_in;
   logic          wpass_ff, wpass_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [FIELD_W-1:0]  res_where_ff, res_where_in;

   logic [POLICY_W-1:0] policy_ff;
   logic [FIELD_W-1:0]  pool_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [FIELD_W-1:0]  rsp_where_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic [AW-1:0] q_b, q_l;
   logic [AW-1:0] el_b, el_l;
   logic          take_ins, avail, adjacent, fits;
   logic [AW:0]   acc_end, len_sum;
   logic [AW-1:0] new_len;

   assign q_b = mem_q[2*AW-1:AW];
   assign q_l = mem_q[AW-1:0];

   // The memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_q <= mem[rd_addr];
   end

   // Register writes are always taken; the user sends them only while idle, unchecked.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= FIT_FIRST;
         pool_ff   <= POOL_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_FIT_POLICY: policy_ff <= csr_chan.data[POLICY_W-1:0];
            CSR_POOL_SIZE:  pool_ff   <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // A new command is taken whenever the sequencer is idle, even while the
   // previous result still sits in the output register.
   assign req_chan.ready = (state_ff == S_IDLE);

   // During a free the table is streamed in order with the released range
   // slotted in before the first extent whose base is not below its start.
   // The open extent is held in the accumulator and written once it closes,
   // which always lands at or below the entry already read.
   assign avail    = !(ins_ff && (j_ff == count_ff));
   assign take_ins = !ins_ff && ((j_ff == count_ff) || (q_b >= start_ff));
   assign el_b     = take_ins ? start_ff : q_b;
   assign el_l     = take_ins ? size_ff  : q_l;
   assign acc_end  = {1'b0, acc_b_ff} + {1'b0, acc_l_ff};
   assign adjacent = ({1'b0, el_b} == acc_end);
   assign len_sum  = {1'b0, acc_l_ff} + {1'b0, el_l};

   assign fits    = (q_l >= size_ff);
   assign new_len = pick_l_ff - size_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      j_in          = j_ff;
      m_in          = m_ff;
      size_in       = size_ff;
      start_in      = start_ff;
      acc_b_in      = acc_b_ff;
      acc_l_in      = acc_l_ff;
      pick_b_in     = pick_b_ff;
      pick_l_in     = pick_l_ff;
      pick_idx_in   = pick_idx_ff;
      found_in      = found_ff;
      ins_in        = ins_ff;
      wpass_in      = wpass_ff;
      res_status_in = res_status_ff;
      res_where_in  = res_where_ff;
      mem_we        = 1'b0;
      mem_wa        = '0;
      mem_wd        = '0;
      rd_addr       = '0;

      unique case (state_ff)
         S_BOOT: begin
            mem_we   = 1'b1;
            mem_wd   = {{AW{1'b0}}, AW'(POOL_RESET)};
            state_in = S_IDLE;
         end

         S_IDLE: begin
            if (req_chan.valid) begin
               size_in       = AW'(req_chan.block_size);
               start_in      = AW'(req_chan.block_start);
               j_in          = '0;
               m_in          = '0;
               ins_in        = 1'b0;
               wpass_in      = 1'b0;
               found_in      = 1'b0;
               res_status_in = ST_OK;
               res_where_in  = '0;
               unique case (req_chan.cmd)
                  CMD_INIT: begin
                     mem_we   = 1'b1;
                     mem_wd   = {{AW{1'b0}}, AW'(pool_ff)};
                     count_in = (pool_ff != '0) ? CW'(1) : '0;
                     state_in = S_DONE;
                  end
                  CMD_ALLOC: state_in = S_A_SCAN;
                  CMD_FREE: begin
                     // A free of nothing leaves the table alone.
                     state_in = (AW'(req_chan.block_size) == '0) ? S_DONE : S_F_RUN;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end

         S_A_SCAN: begin
            if (j_ff == count_ff) begin
               if (!found_ff) begin
                  res_status_in = ST_NOFIT;
                  state_in      = S_DONE;
               end else begin
                  res_where_in = FIELD_W'(pick_b_ff);
                  if ((new_len == '0) && (size_ff != '0)) begin
                     // The extent is used up: close the gap above it.
                     j_in     = CW'(pick_idx_ff) + CW'(1);
                     rd_addr  = IW'(CW'(pick_idx_ff) + CW'(1));
                     state_in = S_A_MOVE;
                  end else begin
                     mem_we   = 1'b1;
                     mem_wa   = pick_idx_ff;
                     mem_wd   = {pick_b_ff + size_ff, new_len};
                     state_in = S_DONE;
                  end
               end
            end else begin
               if (fits) begin
                  if (!found_ff
                      || ((policy_ff == FIT_BEST) && (q_l < pick_l_ff))
                      || ((policy_ff == FIT_WORST) && (q_l > pick_l_ff))) begin
                     found_in    = 1'b1;
                     pick_idx_in = IW'(j_ff);
                     pick_b_in   = q_b;
                     pick_l_in   = q_l;
                  end
               end
               j_in    = j_ff + CW'(1);
               rd_addr = IW'(j_ff + CW'(1));
            end
         end

         S_A_MOVE: begin
            if (j_ff == count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = S_DONE;
            end else begin
               mem_we  = 1'b1;
               mem_wa  = IW'(j_ff - CW'(1));
               mem_wd  = mem_q;
               j_in    = j_ff + CW'(1);
               rd_addr = IW'(j_ff + CW'(1));
            end
         end

         S_F_RUN: begin
            if (avail) begin
               if (take_ins) begin
                  ins_in  = 1'b1;
                  rd_addr = IW'(j_ff);
               end else begin
                  j_in    = j_ff + CW'(1);
                  rd_addr = IW'(j_ff + CW'(1));
               end
               if (m_ff == '0) begin
                  acc_b_in = el_b;
                  acc_l_in = el_l;
                  m_in     = MW'(1);
               end else if (adjacent) begin
                  acc_l_in = len_sum[AW] ? {AW{1'b1}} : len_sum[AW-1:0];
               end else begin
                  mem_we   = wpass_ff;
                  mem_wa   = IW'(m_ff - MW'(1));
                  mem_wd   = {acc_b_ff, acc_l_ff};
                  acc_b_in = el_b;
                  acc_l_in = el_l;
                  m_in     = m_ff + MW'(1);
               end
            end else if (!wpass_ff) begin
               // First pass only counts; the table is rewritten only if it fits.
               if (m_ff > MW'(MAX_EXTENTS)) begin
                  res_status_in = ST_FULL;
                  state_in      = S_DONE;
               end else begin
                  j_in     = '0;
                  m_in     = '0;
                  ins_in   = 1'b0;
                  wpass_in = 1'b1;
               end
            end else begin
               mem_we   = 1'b1;
               mem_wa   = IW'(m_ff - MW'(1));
               mem_wd   = {acc_b_ff, acc_l_ff};
               count_in = CW'(m_ff);
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_BOOT;
         count_ff <= CW'(1);
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff          <= j_in;
      m_ff          <= m_in;
      size_ff       <= size_in;
      start_ff      <= start_in;
      acc_b_ff      <= acc_b_in;
      acc_l_ff      <= acc_l_in;
      pick_b_ff     <= pick_b_in;
      pick_l_ff     <= pick_l_in;
      pick_idx_ff   <= pick_idx_in;
      found_ff      <= found_in;
      ins_ff        <= ins_in;
      wpass_ff      <= wpass_in;
      res_status_ff <= res_status_in;
      res_where_ff  <= res_where_in;
   end

   // Output register: loaded from the finished command once the slot is free.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready)) begin
         rsp_status_ff <= res_status_ff;
         rsp_where_ff  <= res_where_ff;
         rsp_count_ff  <= COUNT_W'(count_ff);
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.status            = rsp_status_ff;
   assign rsp_chan.alloc_start       = rsp_where_ff;
   assign rsp_chan.free_extent_count = rsp_count_ff;

   // The table never holds more extents than it has entries.
   `EFP_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(MAX_EXTENTS), "extent count overflow")
   // The counting pass of a free must leave the memory untouched.
   `EFP_ASSERT_IMPL(a_free_count_pass, clock, reset, (state_ff == S_F_RUN) && mem_we, wpass_ff,
                    "memory written during counting pass")
   // A result appears only after a command has finished.
   `EFP_ASSERT_IMPL(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_DONE),
                    "result without finished command")

endmodule : extent_allocator_fit_policies_top
`default_nettype wire

@@ bench/efp_bench_if.sv @@
// ----------------------------------------------------------------------------
// Bench-side channels for the extent allocator
// The block's own channel interfaces are reused as they are; this file only
// holds the result record type of the bench.
// ----------------------------------------------------------------------------
package efp_bench_pkg;
   import efp_pkg::*;

   // One expected or observed result transfer.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FIELD_W-1:0]  alloc_start;
      logic [COUNT_W-1:0]  free_extent_count;
   } alloc_result_type;
endpackage : efp_bench_pkg

@@ bench/efp_checker.sv @@
// ----------------------------------------------------------------------------
// Extent allocator checker
// Watches the command, result and register channels, keeps its own free
// extent table and compares each result transfer with the predicted one.
// ----------------------------------------------------------------------------
module efp_checker #(
   parameter int MAX_EXTENTS = 16
) (
   input wire clock,
   input wire reset,
   efp_req_if.sink req_chan,
   efp_rsp_if.sink rsp_chan,
   efp_csr_if.sink csr_chan,
   output int      fail_count,
   output int      pending_count
);
   import efp_pkg::*;
   import efp_bench_pkg::*;

   logic [POLICY_W-1:0] fit_policy;
   logic [FIELD_W-1:0]  pool_size;
   logic [FIELD_W-1:0]  ext_base [MAX_EXTENTS];
   logic [FIELD_W-1:0]  ext_len [MAX_EXTENTS];
   int                  ext_count;
   alloc_result_type    expected_results[$];

   function automatic void init_table();
      for (int i = 0; i < MAX_EXTENTS; i++) begin
         ext_base[i] = '0;
         ext_len[i]  = '0;
      end
      ext_len[0] = pool_size;
      ext_count  = (pool_size != 0) ? 1 : 0;
   endfunction

   function automatic logic [STATUS_W-1:0] allocate(input logic [FIELD_W-1:0] size,
                                                    output logic [FIELD_W-1:0] where);
      int  pick;
      bit  found;
      pick  = 0;
      found = 0;
      where = '0;
      for (int i = 0; i < ext_count; i++) begin
         if (ext_len[i] < size) continue;
         if (!found) begin
            pick  = i;
            found = 1;
            if (fit_policy != FIT_BEST && fit_policy != FIT_WORST) break;
         end else if (fit_policy == FIT_BEST && ext_len[i] < ext_len[pick]) begin
            pick = i;
         end else if (fit_policy == FIT_WORST && ext_len[i] > ext_len[pick]) begin
            pick = i;
         end
      end
      if (!found) return ST_NOFIT;
      where          = ext_base[pick];
      ext_base[pick] = ext_base[pick] + size;
      ext_len[pick]  = ext_len[pick] - size;
      if (ext_len[pick] == 0 && size != 0) begin
         for (int i = pick; i + 1 < ext_count; i++) begin
            ext_base[i] = ext_base[i+1];
            ext_len[i]  = ext_len[i+1];
         end
         ext_count--;
      end
      return ST_OK;
   endfunction

   function automatic logic [STATUS_W-1:0] release_range(input logic [FIELD_W-1:0] start,
                                                         input logic [FIELD_W-1:0] size);
      int unsigned tb [MAX_EXTENTS+1];
      int unsigned tl [MAX_EXTENTS+1];
      int          n, m, pos;
      int unsigned sum;
      if (size == 0) return ST_OK;
      n   = 0;
      pos = ext_count;
      for (int i = 0; i < ext_count; i++)
         if (ext_base[i] >= start) begin
            pos = i;
            break;
         end
      for (int i = 0; i < ext_count; i++) begin
         if (i == pos) begin
            tb[n] = start;
            tl[n] = size;
            n++;
         end
         tb[n] = ext_base[i];
         tl[n] = ext_len[i];
         n++;
      end
      if (pos >= ext_count) begin
         tb[n] = start;
         tl[n] = size;
         n++;
      end
      m = 0;
      for (int i = 0; i < n; i++) begin
         if (m > 0 && tb[i] == tb[m-1] + tl[m-1]) begin
            sum     = tl[m-1] + tl[i];
            tl[m-1] = (sum > 65535) ? 65535 : sum;
         end else begin
            tb[m] = tb[i];
            tl[m] = tl[i];
            m++;
         end
      end
      if (m > MAX_EXTENTS) return ST_FULL;
      for (int i = 0; i < m; i++) begin
         ext_base[i] = tb[i][FIELD_W-1:0];
         ext_len[i]  = tl[i][FIELD_W-1:0];
      end
      ext_count = m;
      return ST_OK;
   endfunction

   always @(posedge clock) begin
      alloc_result_type exp_r, got;
      logic [FIELD_W-1:0] where;
      if (reset) begin
         fit_policy = FIT_FIRST;
         pool_size  = POOL_RESET;
         init_table();
         expected_results.delete();
         fail_count = 0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            if (csr_chan.index == CSR_FIT_POLICY) fit_policy = csr_chan.data[POLICY_W-1:0];
            else if (csr_chan.index == CSR_POOL_SIZE) pool_size = csr_chan.data;
         end
         if (req_chan.valid && req_chan.ready) begin
            exp_r = '0;
            case (req_chan.cmd)
               CMD_INIT:  init_table();
               CMD_ALLOC: begin
                  exp_r.status      = allocate(req_chan.block_size, where);
                  exp_r.alloc_start = where;
               end
               CMD_FREE:  exp_r.status = release_range(req_chan.block_start, req_chan.block_size);
               default:   ;
            endcase
            exp_r.free_extent_count = ext_count[COUNT_W-1:0];
            expected_results.push_back(exp_r);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.status, rsp_chan.alloc_start, rsp_chan.free_extent_count};
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result transfer %p", got);
            end else begin
               exp_r = expected_results.pop_front();
               if (got !== exp_r) begin
                  fail_count++;
                  if (fail_count <= 10) $display("result mismatch: expected %p, got %p", exp_r, got);
               end
            end
         end
      end
      pending_count = expected_results.size();
   end

endmodule : efp_checker

@@ bench/extent_allocator_fit_policies_top_test.sv @@
// ----------------------------------------------------------------------------
// Extent allocator testbench
// Drives init, allocate, free and unused commands under all fit policies and
// several pool sizes, with random idling on both channels; the checker
// predicts and compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module extent_allocator_fit_policies_top_test;
   import efp_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   cycle_count = 0;
   bit   calm_phase = 0;     // No idling on either side while set.
   bit   hold_rsp = 0;       // Requests a long stall of the result channel.

   efp_req_if req_chan ();
   efp_rsp_if rsp_chan ();
   efp_csr_if csr_chan ();

   extent_allocator_fit_policies_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source),
      .csr_chan(csr_chan.sink)
   );

   efp_checker checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan.sink),
      .rsp_chan     (rsp_chan.sink),
      .csr_chan     (csr_chan.sink),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   always #5 clock = ~clock;

   // The run is cut off if it ever takes far longer than the slowest legal pace.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("extent_allocator_fit_policies_top test failed");
         $finish;
      end
   end

   // The result side stalls about a third of the time, except in the calm phase.
   // A hold request makes it refuse transfers for a long stretch, so the block
   // fills up and stops taking commands while the sender keeps offering them.
   initial begin
      int hold_cycles;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            for (hold_cycles = 0; hold_cycles < 400; hold_cycles++) @(negedge clock);
            hold_rsp = 0;
         end
         rsp_chan.ready <= calm_phase || ($urandom_range(99) >= 34);
      end
   end

   // Offers one command and holds it until the block takes it. Valid stays
   // high from one command to the next when no idle cycle falls between them.
   task automatic send_cmd(input cmd_type cmd, input logic [FIELD_W-1:0] size,
                           input logic [FIELD_W-1:0] start);
      while (!calm_phase && $urandom_range(99) < 34) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.cmd         <= cmd;
      req_chan.block_size  <= size;
      req_chan.block_start <= start;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // Raw command code, used for the unused code that the enum does not name.
   task automatic send_raw(input logic [CMD_W-1:0] code, input logic [FIELD_W-1:0] size,
                           input logic [FIELD_W-1:0] start);
      send_cmd(cmd_type'(code), size, start);
   endtask

   // Waits until every expected result has come, then lets the block settle.
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (2 * 16 + 10) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [FIELD_W-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= data;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // One random command. Most are well-formed: allocations of modest size and
   // frees of earlier sizes at guessed starts, so the table fragments and merges.
   task automatic random_cmd(ref logic [FIELD_W-1:0] live_start[$],
                             ref logic [FIELD_W-1:0] live_size[$],
                             input logic [FIELD_W-1:0] pool);
      int pick, k;
      logic [FIELD_W-1:0] size;
      pick = $urandom_range(99);
      if (pick < 2) begin
         send_cmd(CMD_INIT, 16'($urandom), 16'($urandom));
         live_start.delete();
         live_size.delete();
      end else if (pick < 50) begin
         size = (pool > 8 && $urandom_range(9) != 0) ? 16'($urandom_range(pool / 8 + 1, 1))
                                                     : 16'($urandom);
         send_cmd(CMD_ALLOC, size, 16'($urandom));
         // The allocated block's start is read back by the checker; the bench
         // only remembers size and a guessed start for frees, taken below.
         live_size.push_back(size);
      end else if (pick < 92 && live_start.size() != 0) begin
         k = $urandom_range(live_start.size() - 1);
         send_cmd(CMD_FREE, live_size[k], live_start[k]);
         live_start.delete(k);
         live_size.delete(k);
      end else if (pick < 97) begin
         send_cmd(CMD_FREE, 16'($urandom_range(pool / 16 + 1)), 16'($urandom_range(pool)));
      end else begin
         send_raw(2'd3, 16'($urandom), 16'($urandom));
      end
   endtask

   // Blocks believed to be handed out, offered back by later frees.
   logic [FIELD_W-1:0] live_start[$];
   logic [FIELD_W-1:0] live_size[$];

   initial begin
      logic [FIELD_W-1:0] pools[5];
      int phase;
      pools = '{16'd1000, 16'd0, 16'd65535, 16'd200, 16'd40};
      req_chan.valid       = 1'b0;
      req_chan.cmd         = CMD_INIT;
      req_chan.block_size  = '0;
      req_chan.block_start = '0;
      csr_chan.valid       = 1'b0;
      csr_chan.index       = CSR_FIT_POLICY;
      csr_chan.data        = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part on the reset pool of 1000 under first fit.
      calm_phase = 1;
      send_cmd(CMD_ALLOC, 16'd0, 16'd0);        // zero-size allocate
      send_cmd(CMD_ALLOC, 16'd100, 16'd0);
      send_cmd(CMD_ALLOC, 16'd50, 16'hFFFF);
      send_cmd(CMD_ALLOC, 16'd65535, 16'd0);    // no fit
      send_cmd(CMD_FREE, 16'd0, 16'd10);        // zero-size free is ignored
      send_cmd(CMD_FREE, 16'd100, 16'd0);       // merges nothing, new extent
      send_cmd(CMD_FREE, 16'd50, 16'd100);      // closes the gap, merges all
      send_raw(2'd3, 16'hFFFF, 16'hFFFF);       // unused command
      // Fragment the pool into many extents to reach a full table.
      send_cmd(CMD_ALLOC, 16'd1000, 16'd0);
      for (int i = 0; i < 17; i++) send_cmd(CMD_FREE, 16'd1, 16'(i * 2));
      send_cmd(CMD_FREE, 16'd1, 16'd65534);     // overflows the table
      send_cmd(CMD_FREE, 16'd65535, 16'd65535); // wide free at the top
      drain();
      calm_phase = 0;

      // Random phases through every policy and several pool sizes.
      for (phase = 0; phase < 8; phase++) begin
         write_reg(CSR_FIT_POLICY, 16'(phase % 4));
         write_reg(CSR_POOL_SIZE, pools[phase % 5]);
         send_cmd(CMD_INIT, 16'($urandom), 16'($urandom));
         live_start.delete();
         live_size.delete();
         calm_phase = (phase == 2);
         for (int n = 0; n < 170; n++) begin
            if (phase == 3 && n == 40) hold_rsp = 1;
            if (phase == 5 && n == 80) drain();
            random_cmd(live_start, live_size, pools[phase % 5]);
            // Pair the newest allocate size with a plausible start so that
            // some frees hit real blocks; the checker gives the truth anyway.
            while (live_size.size() > live_start.size())
               live_start.push_back(16'($urandom_range(pools[phase % 5])));
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("extent_allocator_fit_policies_top test passed");
      end else begin
         $display("extent_allocator_fit_policies_top test failed");
      end
      $finish;
   end

endmodule : extent_allocator_fit_policies_top_test

@@ filelist.f @@
+incdir+rtl/core
rtl/core/efp_pkg.sv
rtl/core/efp_if.sv
rtl/core/extent_allocator_fit_policies_top.sv
bench/efp_bench_if.sv
bench/efp_checker.sv
bench/extent_allocator_fit_policies_top_test.sv
